### src/ssel_pkg.sv
package ssel_pkg;

    localparam int unsigned MvWidth    = 15;
    localparam int unsigned CountWidth = 8;
    localparam int unsigned CfgIdxWidth  = 3;
    localparam int unsigned CfgDataWidth = 15;

    localparam logic [MvWidth-1:0]    StbLowReset    = 15'd4500;
    localparam logic [MvWidth-1:0]    StbHighReset   = 15'd5400;
    localparam logic [CountWidth-1:0] PsOnLowReset   = 8'd8;
    localparam logic [CountWidth-1:0] PsOnHighReset  = 8'd12;
    localparam logic [CountWidth-1:0] PgLimitReset   = 8'd10;

    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_STB_LOW_MV        = 3'd0,
        CFG_STB_HIGH_MV       = 3'd1,
        CFG_PS_ON_WINDOW_LOW  = 3'd2,
        CFG_PS_ON_WINDOW_HIGH = 3'd3,
        CFG_PG_COUNT_LIMIT    = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        MODE_WARMUP       = 3'd0,
        MODE_CHECKING     = 3'd1,
        MODE_INITIALIZING = 3'd2,
        MODE_ON_SUPPLY    = 3'd3,
        MODE_ON_BUFFER    = 3'd4,
        MODE_VOLTAGE_FAIL = 3'd5
    } t_mode;

    typedef enum logic {
        EV_CHECK_TICK = 1'b0,
        EV_POWER_ON   = 1'b1
    } t_event;

    typedef struct packed {
        logic               mode;
        logic [MvWidth-1:0] stb_voltage_mv;
        logic               power_good;
    } t_in_req;

    typedef struct packed {
        logic       ps_on;
        logic       select_supply;
        logic       select_buffer;
        logic [2:0] mode_now;
    } t_out_req;

    typedef struct packed {
        logic [MvWidth-1:0]    stb_low_mv;
        logic [MvWidth-1:0]    stb_high_mv;
        logic [CountWidth-1:0] ps_on_window_low;
        logic [CountWidth-1:0] ps_on_window_high;
        logic [CountWidth-1:0] pg_count_limit;
    } t_cfg;

endpackage

### src/ssel_cfg.sv
module ssel_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ssel_pkg::CfgIdxWidth-1:0]  i_cfg_index,
    input  logic [ssel_pkg::CfgDataWidth-1:0] i_cfg_data,
    output ssel_pkg::t_cfg                    o_cfg
);
    import ssel_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stb_low_mv        <= StbLowReset;
            r_cfg.stb_high_mv       <= StbHighReset;
            r_cfg.ps_on_window_low  <= PsOnLowReset;
            r_cfg.ps_on_window_high <= PsOnHighReset;
            r_cfg.pg_count_limit    <= PgLimitReset;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_STB_LOW_MV:        r_cfg.stb_low_mv        <= i_cfg_data[MvWidth-1:0];
                CFG_STB_HIGH_MV:       r_cfg.stb_high_mv       <= i_cfg_data[MvWidth-1:0];
                CFG_PS_ON_WINDOW_LOW:  r_cfg.ps_on_window_low  <= i_cfg_data[CountWidth-1:0];
                CFG_PS_ON_WINDOW_HIGH: r_cfg.ps_on_window_high <= i_cfg_data[CountWidth-1:0];
                CFG_PG_COUNT_LIMIT:    r_cfg.pg_count_limit    <= i_cfg_data[CountWidth-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### src/ssel_step.sv
module ssel_step (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  ssel_pkg::t_in_req  i_req,
    input  ssel_pkg::t_cfg     i_cfg,
    output ssel_pkg::t_out_req o_res
);
    import ssel_pkg::*;

    t_mode                 r_mode, n_mode;
    logic [CountWidth-1:0] r_qual, n_qual;
    logic [CountWidth-1:0] r_good, n_good;

    logic in_window;
    logic waiting;
    logic ps_on, sel_sup, sel_buf;

    always_comb begin
        n_mode  = r_mode;
        n_qual  = r_qual;
        n_good  = r_good;
        ps_on   = 1'b0;
        sel_sup = 1'b0;
        sel_buf = 1'b0;
        in_window = (i_req.stb_voltage_mv >= i_cfg.stb_low_mv) &&
                    (i_req.stb_voltage_mv <= i_cfg.stb_high_mv);
        waiting   = (r_mode == MODE_ON_BUFFER) || (r_mode == MODE_CHECKING);
        if (t_event'(i_req.mode) == EV_POWER_ON) begin
            n_mode = MODE_CHECKING;
        end else begin
            if (in_window && !i_req.power_good && waiting) begin
                n_qual = r_qual + 1'b1;
            end else begin
                n_qual = '0;
            end
            ps_on = (n_qual > i_cfg.ps_on_window_low) &&
                    (n_qual < i_cfg.ps_on_window_high);
            if (i_req.power_good) begin
                n_good = r_good + 1'b1;
            end else begin
                n_good = '0;
            end
            if ((n_good > i_cfg.pg_count_limit) && (r_mode == MODE_ON_BUFFER)) begin
                n_qual  = '0;
                n_good  = '0;
                n_mode  = MODE_ON_SUPPLY;
                sel_sup = 1'b1;
            end
            if (!i_req.power_good &&
                ((n_mode == MODE_ON_SUPPLY) || (n_mode == MODE_CHECKING))) begin
                n_mode  = MODE_ON_BUFFER;
                sel_buf = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_WARMUP;
            r_qual <= '0;
            r_good <= '0;
        end else if (i_fire) begin
            r_mode <= n_mode;
            r_qual <= n_qual;
            r_good <= n_good;
        end
    end

    assign o_res.ps_on         = ps_on;
    assign o_res.select_supply = sel_sup;
    assign o_res.select_buffer = sel_buf;
    assign o_res.mode_now      = n_mode;

endmodule

### src/supply_source_selector.sv
// Channel   Direction  Signals                         Accepted when
// in        input      i_in_valid, i_in_req            i_in_valid && !o_in_stall
//                      o_in_stall
// out       output     o_out_valid, o_out_req          o_out_valid && !i_out_stall
//                      i_out_stall
// cfg       input      i_cfg_we, i_cfg_index,          i_cfg_we
//                      i_cfg_data
//
// One request per cycle sustained while the output is not stalled; a request passes
// the input register, then the mode/count update into the result register.
// Synchronous active-low reset clears valids, mode and counts, and loads config defaults.
// A stall at the output holds the result; the input stalls only when both
// stages are full.
module supply_source_selector (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  ssel_pkg::t_in_req                 i_in_req,
    output logic                              o_in_stall,
    output logic                              o_out_valid,
    output ssel_pkg::t_out_req                o_out_req,
    input  logic                              i_out_stall,
    input  logic                              i_cfg_we,
    input  logic [ssel_pkg::CfgIdxWidth-1:0]  i_cfg_index,
    input  logic [ssel_pkg::CfgDataWidth-1:0] i_cfg_data
);
    import ssel_pkg::*;

    t_cfg     cfg;
    t_in_req  r_in_req;
    logic     r_in_valid;
    t_out_req r_out_req;
    logic     r_out_valid;
    t_out_req step_res;
    logic     out_free;
    logic     fire;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    ssel_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ssel_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_req   (r_in_req),
        .i_cfg   (cfg),
        .o_res   (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_req <= i_in_req;
        end
        if (fire) begin
            r_out_req <= step_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

endmodule
